// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define GBN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and codes shared by the Go-Back-N sender window and its slot memory.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned SeqW  = 32;
  localparam int unsigned TagW  = 32;
  localparam int unsigned LenW  = 9;
  localparam int unsigned WinW  = 5;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned CfgW  = 16;

  // Input kinds.
  localparam logic [KindW-1:0] KIND_DATA = 3'd0;
  localparam logic [KindW-1:0] KIND_EOD  = 3'd1;
  localparam logic [KindW-1:0] KIND_ACK  = 3'd2;
  localparam logic [KindW-1:0] KIND_FIN  = 3'd3;
  localparam logic [KindW-1:0] KIND_TICK = 3'd4;

  // Result actions.
  localparam logic [KindW-1:0] ACT_SEND   = 3'd0;
  localparam logic [KindW-1:0] ACT_RETX   = 3'd1;
  localparam logic [KindW-1:0] ACT_FIN    = 3'd2;
  localparam logic [KindW-1:0] ACT_REFUSE = 3'd3;
  localparam logic [KindW-1:0] ACT_CLOSED = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_WINDOW  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [WinW-1:0] WinReset   = 5'd4;
  localparam logic [TmoW-1:0] TmoReset   = 16'd4;
  localparam logic [LenW-1:0] MaxPayload = 9'd500;

  // One stored packet descriptor.
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [LenW-1:0] len;
  } slot_entry_t;

endpackage

// ===== design/gbn_slot_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_slot_ram
// Ring of packet descriptors: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbn_slot_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  gbn_pkg::slot_entry_t      wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output gbn_pkg::slot_entry_t      rdata_o
);
  import gbn_pkg::*;

  slot_entry_t mem_q [Depth];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/go_back_n_sender_window.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Sender side of a Go-Back-N ARQ link: window, slot ring, timer, resend walk.
// ----------------------------------------------------------------------------
// Commands enter on start_i with kind_i and its fields; a command transfer
// happens at a rising edge where start_i is high and busy_o is low. Results
// leave on action_o, seq_o, out_tag_o, out_len_o and last_o, each valid for
// exactly one cycle while res_valid_o is high. The receiver cannot stall, so
// every result must be taken when it is strobed. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle: index 0
// is the window size, index 1 the timeout.
// Every command passes through the execute state after its transfer, while
// busy_o is high; a single result (data offer, end of data, peer FIN,
// refusal, closed reply) is strobed in the cycle after it. While open,
// acks and ticks that do not expire give no result. A timer expiry with N
// packets outstanding walks the slot ring through its registered read port,
// one slot per cycle, with busy_o high; the N resends come out one per
// cycle, the last one marked by last_o and strobed right after busy_o falls.
// Reset empties the window, stops the timer, opens the block and loads window
// size 4 and timeout 4. The slot ring is not cleared; only outstanding slots
// are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_sender_window #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [gbn_pkg::KindW-1:0]     kind_i,
  input  logic [gbn_pkg::TagW-1:0]      payload_tag_i,
  input  logic [gbn_pkg::LenW-1:0]      payload_len_i,
  input  logic [gbn_pkg::SeqW-1:0]      ack_seq_i,
  // Result channel
  output logic                          res_valid_o,
  output logic [gbn_pkg::KindW-1:0]     action_o,
  output logic [gbn_pkg::SeqW-1:0]      seq_o,
  output logic [gbn_pkg::TagW-1:0]      out_tag_o,
  output logic [gbn_pkg::LenW-1:0]      out_len_o,
  output logic                          last_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [gbn_pkg::CfgW-1:0]      cfg_data_i
);
  import gbn_pkg::*;

  // Slot index width, outstanding count width and the width used to
  // compare the count against the configured window.
  localparam int unsigned SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW  = (CntW > WinW) ? CntW : WinW;
  localparam int unsigned SumW  = CntW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETX
  } state_e;

  state_e state_q, state_d;

  // Captured command.
  logic [KindW-1:0] kind_q;
  logic [TagW-1:0]  tag_q;
  logic [LenW-1:0]  len_q;
  logic [SeqW-1:0]  ack_q;

  // Configuration.
  logic [WinW-1:0] win_q;
  logic [TmoW-1:0] tmo_q;

  // Window state. outst_q always equals next_q - base_q; the two slot
  // pointers follow base_q and next_q around the ring.
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  next_q, next_d;
  logic [SeqW-1:0]  prev_ack_q, prev_ack_d;
  logic [CntW-1:0]  outst_q, outst_d;
  logic [SlotW-1:0] base_slot_q, base_slot_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic [TmoW-1:0]  timer_q, timer_d;
  logic             run_q, run_d;
  logic             closed_q, closed_d;

  // Resend walk: read issue side and the aligned read-data side.
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [SeqW-1:0]  rd_seq_q, rd_seq_d;
  logic [CntW-1:0]  rd_left_q, rd_left_d;
  logic             pend_q, pend_d;
  logic [SeqW-1:0]  pend_seq_q, pend_seq_d;
  logic             pend_last_q, pend_last_d;

  // Registered result.
  logic             res_valid_q, res_valid_d;
  logic [KindW-1:0] action_q, action_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [TagW-1:0]  otag_q, otag_d;
  logic [LenW-1:0]  olen_q, olen_d;
  logic             last_q, last_d;

  // Slot memory.
  logic        ram_we;
  slot_entry_t ram_wdata;
  slot_entry_t ram_rdata;

  // Derived values.
  logic [WinW-1:0]  eff_win;
  logic             has_room;
  logic [TmoW-1:0]  reload;
  logic [TmoW-1:0]  tick_cnt;
  logic [LenW-1:0]  len_sat;
  logic [SeqW-1:0]  ack_diff;
  logic             ack_hit;
  logic [CntW-1:0]  ack_step;
  logic [SumW-1:0]  slot_sum;
  logic [SlotW-1:0] ack_slot;
  logic [SlotW-1:0] next_slot_inc;
  logic [SlotW-1:0] rd_slot_inc;

  gbn_slot_ram #(
    .Depth (MAX_WINDOW),
    .AddrW (SlotW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  // Window size is used clamped to 1..MAX_WINDOW, a zero timeout as one.
  always_comb begin
    if (win_q == '0) begin
      eff_win = WinW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      eff_win = WinW'(MAX_WINDOW);
    end else begin
      eff_win = win_q;
    end
  end

  assign has_room = CmpW'(outst_q) < CmpW'(eff_win);
  assign reload   = (tmo_q == '0) ? TmoW'(1) : tmo_q;
  assign tick_cnt = timer_q - TmoW'(1);
  assign len_sat  = (len_q > MaxPayload) ? MaxPayload : len_q;

  // A new ack moves the base only if it names an outstanding sequence.
  // The step to the new base is then at most MAX_WINDOW, so the slot
  // pointer wraps with a single compare and subtract.
  assign ack_diff = ack_q - base_q;
  assign ack_hit  = ack_diff < SeqW'(outst_q);
  assign ack_step = ack_diff[CntW-1:0] + CntW'(1);
  assign slot_sum = SumW'(base_slot_q) + SumW'(ack_step);
  assign ack_slot = (32'(slot_sum) >= MAX_WINDOW) ?
                    SlotW'(slot_sum - SumW'(MAX_WINDOW)) : SlotW'(slot_sum);

  assign next_slot_inc = (next_slot_q == SlotW'(MAX_WINDOW - 1)) ?
                         '0 : next_slot_q + SlotW'(1);
  assign rd_slot_inc   = (rd_slot_q == SlotW'(MAX_WINDOW - 1)) ?
                         '0 : rd_slot_q + SlotW'(1);

  assign ram_wdata.tag = tag_q;
  assign ram_wdata.len = len_sat;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    prev_ack_d  = prev_ack_q;
    outst_d     = outst_q;
    base_slot_d = base_slot_q;
    next_slot_d = next_slot_q;
    timer_d     = timer_q;
    run_d       = run_q;
    closed_d    = closed_q;
    rd_slot_d   = rd_slot_q;
    rd_seq_d    = rd_seq_q;
    rd_left_d   = rd_left_q;
    pend_d      = 1'b0;
    pend_seq_d  = pend_seq_q;
    pend_last_d = pend_last_q;
    res_valid_d = 1'b0;
    action_d    = action_q;
    seq_d       = seq_q;
    otag_d      = otag_q;
    olen_d      = olen_q;
    last_d      = last_q;
    ram_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        if (closed_q) begin
          res_valid_d = 1'b1;
          action_d    = ACT_CLOSED;
          seq_d       = '0;
          otag_d      = '0;
          olen_d      = '0;
          last_d      = 1'b1;
        end else begin
          case (kind_q)
            KIND_DATA: begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              seq_d       = next_q;
              if (has_room) begin
                ram_we      = 1'b1;
                action_d    = ACT_SEND;
                otag_d      = tag_q;
                olen_d      = len_sat;
                next_d      = next_q + SeqW'(1);
                next_slot_d = next_slot_inc;
                outst_d     = outst_q + CntW'(1);
                if (outst_q == '0) begin
                  timer_d = reload;
                  run_d   = 1'b1;
                end
              end else begin
                action_d = ACT_REFUSE;
                otag_d   = '0;
                olen_d   = '0;
              end
            end
            KIND_EOD: begin
              // The FIN takes the next sequence without consuming it.
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              seq_d       = next_q;
              otag_d      = '0;
              olen_d      = '0;
              if (has_room) begin
                action_d = ACT_FIN;
                timer_d  = reload;
                run_d    = 1'b1;
              end else begin
                action_d = ACT_REFUSE;
              end
            end
            KIND_ACK: begin
              if (ack_q != prev_ack_q) begin
                prev_ack_d = ack_q;
                if (ack_hit) begin
                  base_d      = ack_q + SeqW'(1);
                  base_slot_d = ack_slot;
                  outst_d     = outst_q - ack_step;
                  if (ack_step == outst_q) begin
                    timer_d = '0;
                    run_d   = 1'b0;
                  end else begin
                    timer_d = reload;
                    run_d   = 1'b1;
                  end
                end
              end
            end
            KIND_FIN: begin
              closed_d    = 1'b1;
              run_d       = 1'b0;
              res_valid_d = 1'b1;
              action_d    = ACT_CLOSED;
              seq_d       = '0;
              otag_d      = '0;
              olen_d      = '0;
              last_d      = 1'b1;
            end
            KIND_TICK: begin
              if (run_q) begin
                timer_d = tick_cnt;
                if (tick_cnt == '0) begin
                  if (outst_q == '0) begin
                    run_d = 1'b0;
                  end else begin
                    timer_d   = reload;
                    rd_slot_d = base_slot_q;
                    rd_seq_d  = base_q;
                    rd_left_d = outst_q;
                    state_d   = ST_RETX;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RETX: begin
        // Issue one slot read per cycle; the data returns from the registered read
        // port in the next cycle, lined up with pend_q.
        if (rd_left_q != '0) begin
          pend_d      = 1'b1;
          pend_seq_d  = rd_seq_q;
          pend_last_d = (rd_left_q == CntW'(1));
          rd_seq_d    = rd_seq_q + SeqW'(1);
          rd_slot_d   = rd_slot_inc;
          rd_left_d   = rd_left_q - CntW'(1);
        end
        if (pend_q) begin
          res_valid_d = 1'b1;
          action_d    = ACT_RETX;
          seq_d       = pend_seq_q;
          otag_d      = ram_rdata.tag;
          olen_d      = ram_rdata.len;
          last_d      = pend_last_q;
          if (pend_last_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WinReset;
      tmo_q       <= TmoReset;
      base_q      <= SeqW'(1);
      next_q      <= SeqW'(1);
      prev_ack_q  <= '0;
      outst_q     <= '0;
      base_slot_q <= '0;
      next_slot_q <= '0;
      timer_q     <= '0;
      run_q       <= 1'b0;
      closed_q    <= 1'b0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      prev_ack_q  <= prev_ack_d;
      outst_q     <= outst_d;
      base_slot_q <= base_slot_d;
      next_slot_q <= next_slot_d;
      timer_q     <= timer_d;
      run_q       <= run_d;
      closed_q    <= closed_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW:  win_q <= cfg_data_i[WinW-1:0];
          CFG_TIMEOUT: tmo_q <= cfg_data_i[TmoW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      kind_q <= kind_i;
      tag_q  <= payload_tag_i;
      len_q  <= payload_len_i;
      ack_q  <= ack_seq_i;
    end
    rd_slot_q   <= rd_slot_d;
    rd_seq_q    <= rd_seq_d;
    pend_seq_q  <= pend_seq_d;
    pend_last_q <= pend_last_d;
    action_q    <= action_d;
    seq_q       <= seq_d;
    otag_q      <= otag_d;
    olen_q      <= olen_d;
    last_q      <= last_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign action_o    = action_q;
  assign seq_o       = seq_q;
  assign out_tag_o   = otag_q;
  assign out_len_o   = olen_q;
  assign last_o      = last_q;

  // The outstanding count mirrors the sequence distance and never
  // overflows the slot ring.
  `GBN_ASSERT(a_outst_tracks_seq, (next_q - base_q) == SeqW'(outst_q),
              "outstanding count out of step with sequence numbers")
  `GBN_ASSERT_NEVER(a_outst_bound, 32'(outst_q) > MAX_WINDOW,
                    "more packets outstanding than slots")
  // A running timer always has a tick left to count.
  `GBN_ASSERT_NEVER(a_timer_live, run_q && (timer_q == '0),
                    "timer running with zero count")
  // The execute cycle sits between a command transfer and its result.
  `GBN_ASSERT(a_no_early_result, (start_i && !busy_o) |=> !res_valid_o,
              "result strobed in the cycle right after a command transfer")
  // Once closed, the block stays closed until reset.
  `GBN_ASSERT(a_closed_sticky, closed_q |=> closed_q,
              "closed state left without reset")

endmodule
